/* hdl/assert_macros.svh */
// Shared assertion macros, clocked on aclk and off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ramct_pkg.sv */
package ramct_pkg;

    localparam int RAMCT_LEAVES = 1024;

    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 40;
    localparam int WT_W   = 16;
    localparam int CNT_W  = 32;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 72;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [VAL_W-1:0]  VAL_MAX    = 40'h7F_FFFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_MIN    = 40'h80_0000_0000;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } ramct_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PS_A,
        ST_PS_B,
        ST_PS_NEXT,
        ST_PU_RD0,
        ST_PU_RD1,
        ST_PU_WL,
        ST_PU_WR,
        ST_PU_WX,
        ST_AP_LEFT,
        ST_AP_RIGHT,
        ST_AP_SHIFT,
        ST_AP_RD,
        ST_AP_WR,
        ST_UP_A,
        ST_UP_B,
        ST_UP_NEXT,
        ST_UL_RD,
        ST_UL_WR,
        ST_RESULT
    } ramct_state_t;

    // one tree node as stored
    typedef struct packed {
        logic [VAL_W-1:0] mn;
        logic [CNT_W-1:0] cnt;
        logic [VAL_W-1:0] pend;
    } ramct_node_t;

    typedef struct packed {
        logic [VAL_W-1:0] mn;
        logic [CNT_W-1:0] cnt;
    } ramct_pair_t;

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    // min with tie count, count saturates
    function automatic ramct_pair_t join_pair(input ramct_pair_t a, input ramct_pair_t b);
        ramct_pair_t r;
        logic [CNT_W:0] sum;
        sum = {1'b0, a.cnt} + {1'b0, b.cnt};
        if ($signed(a.mn) < $signed(b.mn)) begin
            r = a;
        end else if ($signed(b.mn) < $signed(a.mn)) begin
            r = b;
        end else begin
            r.mn  = a.mn;
            r.cnt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/ramct_ram.sv */
module ramct_ram
    import ramct_pkg::*;
#(
    parameter int WIDTH = $bits(ramct_node_t),
    parameter int DEPTH = 2 * RAMCT_LEAVES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hdl/range_add_min_count_tree_top.sv */
// Lazy segment tree: range add, range minimum with tie count.
// Input channel s_*: one operation per transfer, op in s_tuser (0 load, 1 range
// add, 2 range query, 3 ignored). Result channel m_*: one transfer per query.
// Config channel cfg_*: writes size_in_use and empties the whole tree.
// All node state sits in one node memory (min, count, pending add per node)
// with one write port and two registered read ports.
// An operation runs in three passes over the D = log2(padded leaves) levels:
// push pending adds down along the two range edges, apply to the covering
// nodes, pull the edge nodes back up, each pass with walk control per level.
// Queries skip the pull pass. Items are taken one at a time.
// An empty query goes straight to the result step; ignored items end in idle.
// After reset and after every config write a clearing pass writes every node
// (2*padded leaves of them, 2048 for 1024) with s_tready low.
// A query result waits in the output register while m_tready is low; other
// items go on, but the next query holds in its last step with s_tready low
// until the waiting result leaves.
`include "assert_macros.svh"

module range_add_min_count_tree_top
    import ramct_pkg::*;
#(
    parameter int LEAVES = RAMCT_LEAVES
) (
    input  logic                aclk,
    input  logic                aresetn,
    // op from bit 0 up
    input  logic [1:0]          s_tuser,
    // position[9:0], leaf_value[49:10], leaf_weight[65:50], range_low[75:66],
    // range_high[85:76], delta[125:86], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // min_value[39:0], min_count[71:40]
    output logic [M_DATA_W-1:0] m_tdata,
    // range_empty at bit 0
    output logic                m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SIZE_W-1:0]   cfg_data,
    input  logic                cfg_valid,
    output logic                cfg_ready
);

    localparam int D     = $clog2(LEAVES);
    localparam int IDX_W = D + 1;
    localparam int LW    = IDX_W + 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int SW    = $clog2(D + 1);
    localparam int USE_W = (SIZE_W > $clog2(LEAVES + 1)) ? SIZE_W : $clog2(LEAVES + 1);
    localparam logic [D-1:0] ALL_ONES = '1;

    // input fields
    ramct_op_t          in_op;
    logic [POS_W-1:0]   in_position;
    logic [VAL_W-1:0]   in_leaf_value;
    logic [WT_W-1:0]    in_leaf_weight;
    logic [POS_W-1:0]   in_range_low;
    logic [POS_W-1:0]   in_range_high;
    logic [VAL_W-1:0]   in_delta;

    assign in_op          = ramct_op_t'(s_tuser);
    assign in_position    = s_tdata[9:0];
    assign in_leaf_value  = s_tdata[49:10];
    assign in_leaf_weight = s_tdata[65:50];
    assign in_range_low   = s_tdata[75:66];
    assign in_range_high  = s_tdata[85:76];
    assign in_delta       = s_tdata[125:86];

    ramct_state_t state_reg, state_next;
    ramct_state_t ret_reg, ret_next;
    ramct_op_t    op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [D-1:0]      lo_reg, lo_next;
    logic [D-1:0]      hi_reg, hi_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [LW-1:0]     l_reg, l_next;
    logic [LW-1:0]     r_reg, r_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [WT_W-1:0]   wt_reg, wt_next;
    ramct_node_t       ent_reg, ent_next;
    ramct_node_t       chr_reg, chr_next;
    ramct_pair_t       acc_reg, acc_next;
    logic              empty_reg, empty_next;
    logic              m_valid_reg, m_valid_next;
    ramct_pair_t       m_res_reg, m_res_next;
    logic              m_empty_reg, m_empty_next;

    // memory ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    ramct_node_t       ram_wdata;
    logic              ram_re_a, ram_re_b;
    logic [IDX_W-1:0]  ram_ra_a, ram_ra_b;
    ramct_node_t       ram_rd_a, ram_rd_b;

    ramct_ram #(
        .WIDTH ($bits(ramct_node_t)),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_nodes (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_ra_a),
        .rdata_a (ram_rd_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_ra_b),
        .rdata_b (ram_rd_b)
    );

    // range decode at accept
    logic [USE_W-1:0] size_ext, n_use, n_m1, pos_ext, lo_ext, hi_ext, hi_clip;
    logic             rng_empty, load_skip;

    assign size_ext  = USE_W'(size_reg);
    assign n_use     = (size_ext < USE_W'(LEAVES)) ? size_ext : USE_W'(LEAVES);
    assign n_m1      = n_use - USE_W'(1);
    assign pos_ext   = USE_W'(in_position);
    assign lo_ext    = USE_W'(in_range_low);
    assign hi_ext    = USE_W'(in_range_high);
    assign hi_clip   = (hi_ext > n_m1) ? n_m1 : hi_ext;
    assign rng_empty = (n_use == '0) || (lo_ext > hi_clip);
    assign load_skip = (pos_ext >= n_use);

    // edge nodes at the current level: an ancestor of the low edge is cut by
    // the range when low is not aligned, of the high edge when high+1 is not
    logic [D-1:0]     lvl_mask;
    logic [IDX_W-1:0] lo_node, hi_node;
    logic             lo_part, hi_part, hi_take;

    assign lvl_mask = ~(ALL_ONES << s_reg);
    assign lo_node  = {1'b1, lo_reg} >> s_reg;
    assign hi_node  = {1'b1, hi_reg} >> s_reg;
    assign lo_part  = (lo_reg & lvl_mask) != '0;
    assign hi_part  = (hi_reg & lvl_mask) != lvl_mask;
    assign hi_take  = hi_part && !(lo_part && (lo_node == hi_node));

    logic [IDX_W-1:0] child_l, child_r;
    logic             child_inner, tgt_inner;

    assign child_l     = {tgt_reg[D-1:0], 1'b0};
    assign child_r     = {tgt_reg[D-1:0], 1'b1};
    assign child_inner = (tgt_reg[D-1] == 1'b0);
    assign tgt_inner   = (tgt_reg[D] == 1'b0);

    logic [LW-1:0] r_dec;
    assign r_dec = r_reg - LW'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_op)
                        OP_LOAD:  state_next = load_skip ? ST_IDLE : ST_PS_A;
                        OP_ADD:   state_next = rng_empty ? ST_IDLE : ST_PS_A;
                        OP_QUERY: state_next = rng_empty ? ST_RESULT : ST_PS_A;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PS_A:     state_next = lo_part ? ST_PU_RD0 : ST_PS_B;
            ST_PS_B:     state_next = hi_take ? ST_PU_RD0 : ST_PS_NEXT;
            ST_PS_NEXT:  state_next = (s_reg == SW'(1)) ? ST_AP_LEFT : ST_PS_A;
            ST_PU_RD0:   state_next = ST_PU_RD1;
            ST_PU_RD1:   state_next = ST_PU_WL;
            ST_PU_WL:    state_next = ST_PU_WR;
            ST_PU_WR:    state_next = ST_PU_WX;
            ST_PU_WX:    state_next = ret_reg;
            ST_AP_LEFT: begin
                if (l_reg >= r_reg) begin
                    state_next = (op_reg == OP_QUERY) ? ST_RESULT : ST_UP_A;
                end else begin
                    state_next = l_reg[0] ? ST_AP_RD : ST_AP_RIGHT;
                end
            end
            ST_AP_RIGHT: state_next = r_reg[0] ? ST_AP_RD : ST_AP_SHIFT;
            ST_AP_SHIFT: state_next = ST_AP_LEFT;
            ST_AP_RD:    state_next = (op_reg == OP_LOAD) ? ret_reg : ST_AP_WR;
            ST_AP_WR:    state_next = ret_reg;
            ST_UP_A:     state_next = lo_part ? ST_UL_RD : ST_UP_B;
            ST_UP_B:     state_next = hi_take ? ST_UL_RD : ST_UP_NEXT;
            ST_UP_NEXT:  state_next = (s_reg == SW'(D)) ? ST_IDLE : ST_UP_A;
            ST_UL_RD:    state_next = ST_UL_WR;
            ST_UL_WR:    state_next = ret_reg;
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
        // a config write restarts the clearing pass
        if (cfg_valid) state_next = ST_CLEAR;
    end

    // datapath and memory control
    always_comb begin
        ret_next     = ret_reg;
        op_next      = op_reg;
        size_next    = size_reg;
        clr_next     = clr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        s_next       = s_reg;
        tgt_next     = tgt_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        val_next     = val_reg;
        wt_next      = wt_reg;
        ent_next     = ent_reg;
        chr_next     = chr_reg;
        acc_next     = acc_reg;
        empty_next   = empty_reg;
        m_res_next   = m_res_reg;
        m_empty_next = m_empty_reg;
        m_valid_next = m_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = tgt_reg;
        ram_wdata = ent_reg;
        ram_re_a  = 1'b0;
        ram_re_b  = 1'b0;
        ram_ra_a  = tgt_reg;
        ram_ra_b  = child_r;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '{mn: VAL_MAX, cnt: '0, pend: '0};
                clr_next  = clr_reg + IDX_W'(1);
            end
            ST_IDLE: begin
                op_next    = in_op;
                s_next     = SW'(D);
                acc_next   = '{mn: VAL_MAX, cnt: '0};
                empty_next = rng_empty;
                if (in_op == OP_LOAD) begin
                    lo_next  = D'(pos_ext);
                    hi_next  = D'(pos_ext);
                    val_next = in_leaf_value;
                end else begin
                    lo_next  = D'(lo_ext);
                    hi_next  = D'(hi_clip);
                    val_next = in_delta;
                end
                wt_next = in_leaf_weight;
            end
            ST_PS_A: begin
                tgt_next = lo_node;
                ret_next = ST_PS_B;
            end
            ST_PS_B: begin
                tgt_next = hi_node;
                ret_next = ST_PS_NEXT;
            end
            ST_PS_NEXT: begin
                s_next = s_reg - SW'(1);
                l_next = LW'({1'b1, lo_reg});
                r_next = LW'({1'b1, hi_reg}) + LW'(1);
            end
            ST_PU_RD0: begin
                ram_re_a = 1'b1;
            end
            ST_PU_RD1: begin
                ent_next = ram_rd_a;
                ram_re_a = 1'b1;
                ram_re_b = 1'b1;
                ram_ra_a = child_l;
                ram_ra_b = child_r;
            end
            ST_PU_WL: begin
                chr_next         = ram_rd_b;
                ram_we           = 1'b1;
                ram_waddr        = child_l;
                ram_wdata        = ram_rd_a;
                ram_wdata.mn     = sat_add(ram_rd_a.mn, ent_reg.pend);
                if (child_inner) ram_wdata.pend = sat_add(ram_rd_a.pend, ent_reg.pend);
            end
            ST_PU_WR: begin
                ram_we           = 1'b1;
                ram_waddr        = child_r;
                ram_wdata        = chr_reg;
                ram_wdata.mn     = sat_add(chr_reg.mn, ent_reg.pend);
                if (child_inner) ram_wdata.pend = sat_add(chr_reg.pend, ent_reg.pend);
            end
            ST_PU_WX: begin
                ram_we         = 1'b1;
                ram_wdata      = ent_reg;
                ram_wdata.pend = '0;
            end
            ST_AP_LEFT: begin
                tgt_next = l_reg[IDX_W-1:0];
                l_next   = (l_reg < r_reg && l_reg[0]) ? l_reg + LW'(1) : l_reg;
                ret_next = ST_AP_RIGHT;
                s_next   = SW'(1);
            end
            ST_AP_RIGHT: begin
                tgt_next = r_dec[IDX_W-1:0];
                if (r_reg[0]) r_next = r_dec;
                ret_next = ST_AP_SHIFT;
            end
            ST_AP_SHIFT: begin
                l_next = l_reg >> 1;
                r_next = r_reg >> 1;
            end
            ST_AP_RD: begin
                if (op_reg == OP_LOAD) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{mn: val_reg, cnt: CNT_W'(wt_reg), pend: '0};
                end else begin
                    ram_re_a = 1'b1;
                end
            end
            ST_AP_WR: begin
                if (op_reg == OP_QUERY) begin
                    acc_next = join_pair(acc_reg, '{mn: ram_rd_a.mn, cnt: ram_rd_a.cnt});
                end else begin
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rd_a;
                    ram_wdata.mn = sat_add(ram_rd_a.mn, val_reg);
                    if (tgt_inner) ram_wdata.pend = sat_add(ram_rd_a.pend, val_reg);
                end
            end
            ST_UP_A: begin
                tgt_next = lo_node;
                ret_next = ST_UP_B;
            end
            ST_UP_B: begin
                tgt_next = hi_node;
                ret_next = ST_UP_NEXT;
            end
            ST_UP_NEXT: begin
                s_next = s_reg + SW'(1);
            end
            ST_UL_RD: begin
                ram_re_a = 1'b1;
                ram_re_b = 1'b1;
                ram_ra_a = child_l;
                ram_ra_b = child_r;
            end
            ST_UL_WR: begin
                acc_next  = acc_reg;
                ram_we    = 1'b1;
                {ram_wdata.mn, ram_wdata.cnt} =
                    join_pair('{mn: ram_rd_a.mn, cnt: ram_rd_a.cnt},
                              '{mn: ram_rd_b.mn, cnt: ram_rd_b.cnt});
                ram_wdata.pend = '0;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = acc_reg;
                    m_empty_next = empty_reg;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase

        if (cfg_valid) begin
            size_next = cfg_data;
            clr_next  = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            size_reg    <= SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            size_reg    <= size_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        op_reg      <= op_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        s_reg       <= s_next;
        tgt_reg     <= tgt_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        val_reg     <= val_next;
        wt_reg      <= wt_next;
        ent_reg     <= ent_next;
        chr_reg     <= chr_next;
        acc_reg     <= acc_next;
        empty_reg   <= empty_next;
        m_res_reg   <= m_res_next;
        m_empty_reg <= m_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.cnt, m_res_reg.mn};
    assign m_tuser  = m_empty_reg;

    `CHK_NOW(a_push_inner, state_reg == ST_PU_RD0, tgt_reg[D] == 1'b0 && tgt_reg != '0, "push on a leaf or node zero")
    `CHK_NOW(a_apply_node, state_reg == ST_AP_RD, tgt_reg != '0, "apply on node zero")
    `CHK_NEXT(a_cfg_clears, cfg_valid && cfg_ready, state_reg == ST_CLEAR, "config write without clearing pass")

endmodule

/* sim/tb_top.sv */
module tb_top;
    import ramct_pkg::*;

    // Tree mirror geometry and timing budgets
    localparam int     PAD          = 1024;           // padded leaf count
    localparam longint TOP_VAL      = 64'sd549755813887;
    localparam longint BOTTOM_VAL   = -64'sd549755813888;
    localparam longint COUNT_CEIL   = 64'hFFFF_FFFF;
    localparam int     SETTLE_CYCLES = 300;           // one slow item plus margin
    localparam int     HOLD_CYCLES   = 600;           // long receiver hold-off
    localparam int     QUIET_LIMIT   = 20000;         // clearing pass + hold + items

    typedef struct {
        longint mn;
        longint cnt;
    } span_t;

    typedef struct packed {
        logic [VAL_W-1:0] mn;
        logic [CNT_W-1:0] cnt;
        logic             empty;
    } answer_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic [1:0]          s_tuser;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [SIZE_W-1:0]   cfg_data;
    logic                cfg_valid;
    logic                cfg_ready;

    // Per-node mirror of the lazy tree, node 1 is the root
    longint      mir_min [2*PAD];
    longint      mir_cnt [2*PAD];
    longint      mir_pend[2*PAD];
    int unsigned mir_size;
    answer_t     answers_due[$];

    int mismatches = 0;
    int quiet      = 0;
    bit src_idle   = 1'b1;
    bit snk_idle   = 1'b1;
    bit hold_req   = 1'b0;

    always #10 aclk = ~aclk;

    range_add_min_count_tree_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // ---------------- tree mirror ----------------

    function automatic longint sat40(longint a, longint b);
        longint s;
        s = a + b;
        if (s > TOP_VAL) return TOP_VAL;
        if (s < BOTTOM_VAL) return BOTTOM_VAL;
        return s;
    endfunction

    // min of two spans, weights of equal minima add up and saturate
    function automatic span_t merge_span(span_t a, span_t b);
        span_t r;
        if (a.mn != b.mn) return (a.mn < b.mn) ? a : b;
        r.mn  = a.mn;
        r.cnt = a.cnt + b.cnt;
        if (r.cnt > COUNT_CEIL) r.cnt = COUNT_CEIL;
        return r;
    endfunction

    function automatic void mirror_clear();
        for (int i = 0; i < 2*PAD; i++) begin
            mir_min[i]  = TOP_VAL;
            mir_cnt[i]  = 0;
            mir_pend[i] = 0;
        end
    endfunction

    function automatic void tag_node(int i, longint v);
        mir_min[i] = sat40(mir_min[i], v);
        if (i < PAD) mir_pend[i] = sat40(mir_pend[i], v);
    endfunction

    function automatic void push_tag(int i);
        if (i < PAD && mir_pend[i] != 0) begin
            tag_node(2*i, mir_pend[i]);
            tag_node(2*i+1, mir_pend[i]);
            mir_pend[i] = 0;
        end
    endfunction

    function automatic void refresh(int i);
        span_t l, r, m;
        l.mn = mir_min[2*i];   l.cnt = mir_cnt[2*i];
        r.mn = mir_min[2*i+1]; r.cnt = mir_cnt[2*i+1];
        m = merge_span(l, r);
        mir_min[i] = m.mn;
        mir_cnt[i] = m.cnt;
    endfunction

    function automatic void add_span(int a, int b, longint v, int i, int lo, int hi);
        int mid;
        if (b < lo || hi < a) return;
        if (a <= lo && hi <= b) begin
            tag_node(i, v);
            return;
        end
        push_tag(i);
        mid = (lo + hi) >> 1;
        add_span(a, b, v, 2*i, lo, mid);
        add_span(a, b, v, 2*i+1, mid+1, hi);
        refresh(i);
    endfunction

    function automatic span_t min_span(int a, int b, int i, int lo, int hi);
        span_t r;
        int mid;
        if (b < lo || hi < a) begin
            r.mn = TOP_VAL; r.cnt = 0;
            return r;
        end
        if (a <= lo && hi <= b) begin
            r.mn = mir_min[i]; r.cnt = mir_cnt[i];
            return r;
        end
        push_tag(i);
        mid = (lo + hi) >> 1;
        return merge_span(min_span(a, b, 2*i, lo, mid), min_span(a, b, 2*i+1, mid+1, hi));
    endfunction

    // applies one accepted operation, queues the answer of a query
    function automatic void mirror_op(ramct_op_t op, int pos, longint val, int wt,
                                      int lo, int hi, longint dl);
        int      n, i, a, b, mid;
        bit      empty;
        span_t   r;
        answer_t ans;
        n = (mir_size < PAD) ? mir_size : PAD;
        if (op == OP_LOAD) begin
            if (pos >= n) return;
            i = 1; a = 0; b = PAD - 1;
            while (i < PAD) begin
                push_tag(i);
                mid = (a + b) >> 1;
                if (pos <= mid) begin
                    i = 2*i; b = mid;
                end else begin
                    i = 2*i + 1; a = mid + 1;
                end
            end
            mir_min[i] = val;
            mir_cnt[i] = wt;
            for (i = i >> 1; i >= 1; i = i >> 1) refresh(i);
            return;
        end
        if (op == OP_NONE) return;
        empty = (n == 0);
        if (!empty) begin
            if (hi > n - 1) hi = n - 1;
            if (lo > hi) empty = 1'b1;
        end
        if (op == OP_ADD) begin
            if (!empty) add_span(lo, hi, dl, 1, 0, PAD - 1);
            return;
        end
        if (empty) begin
            ans.mn = VAL_MAX; ans.cnt = '0; ans.empty = 1'b1;
        end else begin
            r = min_span(lo, hi, 1, 0, PAD - 1);
            ans.mn = r.mn[VAL_W-1:0]; ans.cnt = r.cnt[CNT_W-1:0]; ans.empty = 1'b0;
        end
        answers_due.push_back(ans);
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[VAL_W-1:0], 0);
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[VAL_W-1:0] !== want.mn)
                    report_mismatch("min_value", m_tdata[VAL_W-1:0], want.mn);
                if (m_tdata[VAL_W+CNT_W-1:VAL_W] !== want.cnt)
                    report_mismatch("min_count", m_tdata[VAL_W+CNT_W-1:VAL_W], want.cnt);
                if (m_tuser !== want.empty)
                    report_mismatch("range_empty", m_tuser, want.empty);
            end
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (snk_idle && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // ---------------- stimulus helpers ----------------

    // called at a falling edge; returns at a falling edge
    task automatic send_op(ramct_op_t op, int pos = 0, longint val = 0, int wt = 0,
                           int lo = 0, int hi = 0, longint dl = 0);
        s_tuser  = op;
        s_tdata  = {2'b00, dl[39:0], hi[9:0], lo[9:0], wt[15:0], val[39:0], pos[9:0]};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        mirror_op(op, pos, val, wt, lo, hi, dl);
        @(negedge aclk);
        s_tvalid = 1'b0;
        if (src_idle && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 13)) @(negedge aclk);
    endtask

    task automatic wait_idle(bit settle);
        while (answers_due.size() != 0) @(negedge aclk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_size(int v);
        wait_idle(1'b1);
        cfg_data  = v[SIZE_W-1:0];
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        mir_size = v & 'h7FF;
        mirror_clear();
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic longint pick_value();
        logic [39:0] r;
        case ($urandom_range(0, 9))
            0: return TOP_VAL;
            1: return BOTTOM_VAL;
            2, 3: begin
                r = 40'({$urandom, $urandom});
                return longint'($signed(r));
            end
            default: return longint'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed_ops();
        send_op(OP_QUERY, 0, 0, 0, 0, 1023);          // unloaded positions: sentinel, weight 0
        send_op(OP_LOAD, 0, BOTTOM_VAL, 65535);
        send_op(OP_LOAD, 1023, TOP_VAL, 0);
        send_op(OP_LOAD, 5, -1, 1);
        send_op(OP_LOAD, 6, -1, 65535);
        send_op(OP_QUERY, 0, 0, 0, 1, 1023);          // tie on -1
        send_op(OP_ADD, 0, 0, 0, 0, 1023, BOTTOM_VAL); // saturates low
        send_op(OP_QUERY, 0, 0, 0, 0, 1023);
        send_op(OP_ADD, 0, 0, 0, 0, 1023, TOP_VAL);
        send_op(OP_ADD, 0, 0, 0, 0, 1023, TOP_VAL);    // saturates high
        send_op(OP_QUERY, 0, 0, 0, 1000, 1023);
        send_op(OP_ADD, 0, 0, 0, 3, 700, -12345);
        send_op(OP_LOAD, 300, 77, 9);                  // load under pending adds
        send_op(OP_QUERY, 0, 0, 0, 299, 301);
        send_op(OP_QUERY, 0, 0, 0, 9, 8);              // reversed range
        send_op(OP_ADD, 0, 0, 0, 9, 8, 55);
        send_op(OP_NONE, 1023, -1, 65535, 1023, 1023, -1);
        send_op(OP_QUERY, 0, 0, 0, 0, 0);
        send_op(OP_QUERY, 0, 0, 0, 1023, 1023);
    endtask

    task automatic test_size_edges();
        write_size(0);                                 // nothing in use
        send_op(OP_LOAD, 0, 4, 4);
        send_op(OP_ADD, 0, 0, 0, 0, 1023, 3);
        send_op(OP_QUERY, 0, 0, 0, 0, 1023);
        write_size(1);
        send_op(OP_LOAD, 1, 4, 4);                     // out of use, ignored
        send_op(OP_LOAD, 0, 8, 2);
        send_op(OP_QUERY, 0, 0, 0, 0, 1023);           // high end clipped
        send_op(OP_QUERY, 0, 0, 0, 1, 1023);           // empty after clipping
        write_size(2047);                              // effective size is the full tree
        send_op(OP_LOAD, 1023, -9, 3);
        send_op(OP_QUERY, 0, 0, 0, 512, 1023);
    endtask

    task automatic random_phase(int size_val, int items, bit load_all);
        int     n, k, lo, hi, pos;
        longint dl;
        write_size(size_val);
        n = (mir_size < PAD) ? mir_size : PAD;
        if (load_all)
            for (int p = 0; p < n; p++) send_op(OP_LOAD, p, pick_value(), $urandom_range(0, 65535));
        repeat (items) begin
            k   = $urandom_range(0, 99);
            lo  = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
            hi  = ($urandom_range(0, 7) == 0 || n == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(lo, n - 1);
            pos = ($urandom_range(0, 9) == 0 || n == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, n - 1);
            dl  = ($urandom_range(0, 24) == 0) ? pick_value()
                                               : longint'($urandom_range(0, 60)) - 30;
            if (k < 30)
                send_op(OP_LOAD, pos, pick_value(), $urandom_range(0, 65535));
            else if (k < 55)
                send_op(OP_ADD, $urandom_range(0, 1023), 0, 0, lo, hi, dl);
            else if (k < 96)
                send_op(OP_QUERY, $urandom_range(0, 1023), 0, 0, lo, hi, 0);
            else
                send_op(OP_NONE, pos, pick_value(), $urandom_range(0, 65535), lo, hi, dl);
        end
    endtask

    // receiver holds off while the sender keeps offering, then the sender
    // pauses until every answer is back
    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_req = 1'b1;
        for (int j = 0; j < 14; j++) begin
            if (j % 3 == 0) send_op(OP_ADD, 0, 0, 0, j, 900, 1);
            else            send_op(OP_QUERY, 0, 0, 0, j, 1000 - j);
        end
        wait_idle(1'b0);
        src_idle = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tuser   = OP_LOAD;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        cfg_data  = '0;
        cfg_valid = 1'b0;
        mir_size  = 1024;
        mirror_clear();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_ops();
        test_size_edges();
        random_phase(1024, 450, 1'b0);
        test_backpressure();
        random_phase(37, 260, 1'b1);
        random_phase(1, 120, 1'b0);
        random_phase(2047, 250, 1'b0);
        random_phase(0, 40, 1'b0);
        random_phase(200, 250, 1'b1);
        // closing stretch with no idling on either side
        src_idle = 1'b0;
        snk_idle = 1'b0;
        random_phase(16, 200, 1'b1);

        wait_idle(1'b1);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
